>>> hw/rtl/skt_pkg.sv
`timescale 1ns / 1ps
package skt_pkg;

  localparam int KEY_W = 16;
  localparam int POS_W = 4;
  localparam int ST_W  = 2;

  typedef enum logic [ST_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_DUP    = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  typedef struct packed {
    logic             kind;
    logic [KEY_W-1:0] key_time;
    logic [POS_W-1:0] del_position;
  } in_item_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [POS_W-1:0] position;
    logic [KEY_W-1:0] entry_key;
    logic [KEY_W-1:0] frame_mark;
    logic             entry_valid;
    logic             last;
  } out_item_t;

  localparam logic KIND_ADD = 1'b0;
  localparam logic KIND_DEL = 1'b1;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_ZERO,
    IDX_POS,
    IDX_INC,
    IDX_DEC,
    IDX_END
  } idx_op_t;

  typedef enum logic [1:0] {
    RD_IDX,
    RD_PREV,
    RD_NEXT
  } rd_sel_t;

  typedef enum logic {
    WR_RDATA,
    WR_KEY
  } wr_sel_t;

  typedef struct packed {
    logic    load_item;
    idx_op_t idx_op;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    mem_we;
    wr_sel_t wr_sel;
    logic    at_load;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    set_status;
    status_t status;
    logic    div_start;
    logic    out_load_entry;
    logic    out_load_empty;
  } cmd_t;

  typedef struct packed {
    logic kind_del;
    logic full;
    logic pos_bad;
    logic empty;
    logic idx_eq_count;
    logic idx_eq_at;
    logic idx_last;
    logic hit;
    logic above;
    logic div_done;
    logic out_taken;
    logic out_last;
  } sts_t;

endpackage

>>> hw/rtl/skt_div.sv
`timescale 1ns / 1ps
module skt_div
  import skt_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [KEY_W-1:0] dividend,
  input  logic [KEY_W-1:0] divisor,
  output logic             done,
  output logic [KEY_W-1:0] quotient
);

  localparam int CNT_W = $clog2(KEY_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [KEY_W-1:0] rem;
  logic [KEY_W-1:0] quo;
  logic [KEY_W:0]   shifted;
  logic [KEY_W:0]   diff;
  logic             ge;

  // restoring, one quotient bit per cycle; a zero divisor yields all ones
  assign shifted  = {rem, quo[KEY_W-1]};
  assign ge       = shifted >= {1'b0, divisor};
  assign diff     = shifted - {1'b0, divisor};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(KEY_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= ge ? diff[KEY_W-1:0] : shifted[KEY_W-1:0];
      quo <= {quo[KEY_W-2:0], ge};
    end
  end

endmodule

>>> hw/rtl/skt_dp.sv
`timescale 1ns / 1ps
module skt_dp
  import skt_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd,
  output sts_t             sts,
  input  logic             cfg_we,
  input  logic [KEY_W-1:0] cfg_wdata,
  input  in_item_t         in_item,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_item
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  logic [KEY_W-1:0] mem [DEPTH];
  in_item_t         item;
  logic [KEY_W-1:0] unit_time;
  logic [CW-1:0]    idx;
  logic [CW-1:0]    at;
  logic [CW-1:0]    count;
  logic [KEY_W-1:0] rdata;
  status_t          status;
  logic [CW-1:0]    idx_prev;
  logic [CW-1:0]    idx_succ;
  logic [AW-1:0]    raddr;
  logic             div_done;
  logic [KEY_W-1:0] quotient;

  assign idx_prev = idx - CW'(1);
  assign idx_succ = idx + CW'(1);

  always_comb begin
    case (cmd.rd_sel)
      RD_PREV: raddr = idx_prev[AW-1:0];
      RD_NEXT: raddr = idx_succ[AW-1:0];
      default: raddr = idx[AW-1:0];
    endcase
  end

  assign sts.kind_del     = (item.kind == KIND_DEL);
  assign sts.full         = (count == CW'(DEPTH));
  assign sts.pos_bad      = CMPW'(item.del_position) >= CMPW'(count);
  assign sts.empty        = (count == '0);
  assign sts.idx_eq_count = (idx == count);
  assign sts.idx_eq_at    = (idx == at);
  assign sts.idx_last     = ({1'b0, idx} + {{CW{1'b0}}, 1'b1}) >= {1'b0, count};
  assign sts.hit          = (rdata == item.key_time);
  assign sts.above        = (rdata > item.key_time);
  assign sts.div_done     = div_done;
  assign sts.out_taken    = out_valid && !out_stall;
  assign sts.out_last     = out_item.last;

  skt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (rdata),
    .divisor  (unit_time),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_time <= KEY_W'(1);
      count     <= '0;
      idx       <= '0;
      at        <= '0;
      status    <= ST_OK;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unit_time <= cfg_wdata;
      end
      case (cmd.idx_op)
        IDX_ZERO: idx <= '0;
        IDX_POS:  idx <= CW'(item.del_position);
        IDX_INC:  idx <= idx_succ;
        IDX_DEC:  idx <= idx_prev;
        IDX_END:  idx <= count;
        default:  idx <= idx;
      endcase
      if (cmd.at_load) begin
        at <= idx;
      end
      if (cmd.cnt_inc) begin
        count <= count + CW'(1);
      end else if (cmd.cnt_dec) begin
        count <= count - CW'(1);
      end
      if (cmd.set_status) begin
        status <= cmd.status;
      end
      if (cmd.out_load_entry || cmd.out_load_empty) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item <= in_item;
    end
    if (cmd.out_load_entry) begin
      out_item.status      <= status;
      out_item.position    <= POS_W'(idx);
      out_item.entry_key   <= rdata;
      out_item.frame_mark  <= quotient;
      out_item.entry_valid <= 1'b1;
      out_item.last        <= sts.idx_last;
    end else if (cmd.out_load_empty) begin
      out_item.status      <= status;
      out_item.position    <= '0;
      out_item.entry_key   <= '0;
      out_item.frame_mark  <= '0;
      out_item.entry_valid <= 1'b0;
      out_item.last        <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      mem[idx[AW-1:0]] <= (cmd.wr_sel == WR_KEY) ? item.key_time : rdata;
    end
    if (cmd.rd_en) begin
      rdata <= mem[raddr];
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above depth");

  a_wr_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.mem_we |-> (idx < CW'(DEPTH)))
    else $error("table write out of range");

  a_no_add_when_full: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_inc |-> !sts.full)
    else $error("insert into full table");

  a_out_gap: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall) |=> !out_valid)
    else $error("result reloaded right after handoff");

endmodule

>>> hw/rtl/skt_ctrl.sv
`timescale 1ns / 1ps
module skt_ctrl
  import skt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SH_RD,
    S_SH_WR,
    S_DEL_RD,
    S_DEL_WR,
    S_LIST,
    S_LS_RD,
    S_LS_DIV,
    S_LS_WAIT,
    S_OUT
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next         = state;
    cmd.load_item      = 1'b0;
    cmd.idx_op         = IDX_HOLD;
    cmd.rd_en          = 1'b0;
    cmd.rd_sel         = RD_IDX;
    cmd.mem_we         = 1'b0;
    cmd.wr_sel         = WR_RDATA;
    cmd.at_load        = 1'b0;
    cmd.cnt_inc        = 1'b0;
    cmd.cnt_dec        = 1'b0;
    cmd.set_status     = 1'b0;
    cmd.status         = ST_OK;
    cmd.div_start      = 1'b0;
    cmd.out_load_entry = 1'b0;
    cmd.out_load_empty = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.kind_del) begin
          if (sts.pos_bad) begin
            cmd.set_status = 1'b1;
            cmd.status     = ST_BADPOS;
            state_next     = S_LIST;
          end else begin
            cmd.idx_op = IDX_POS;
            state_next = S_DEL_RD;
          end
        end else if (sts.full) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_FULL;
          state_next     = S_LIST;
        end else begin
          cmd.idx_op = IDX_ZERO;
          state_next = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        if (sts.idx_eq_count) begin
          cmd.at_load = 1'b1;
          state_next  = S_SH_RD;
        end else begin
          cmd.rd_en  = 1'b1;
          state_next = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (sts.hit) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_DUP;
          state_next     = S_LIST;
        end else if (sts.above) begin
          // insert point found; walk back from the end shifting up
          cmd.at_load = 1'b1;
          cmd.idx_op  = IDX_END;
          state_next  = S_SH_RD;
        end else begin
          cmd.idx_op = IDX_INC;
          state_next = S_SCAN_RD;
        end
      end
      S_SH_RD: begin
        if (sts.idx_eq_at) begin
          cmd.mem_we     = 1'b1;
          cmd.wr_sel     = WR_KEY;
          cmd.cnt_inc    = 1'b1;
          cmd.set_status = 1'b1;
          cmd.status     = ST_OK;
          state_next     = S_LIST;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PREV;
          state_next = S_SH_WR;
        end
      end
      S_SH_WR: begin
        cmd.mem_we = 1'b1;
        cmd.idx_op = IDX_DEC;
        state_next = S_SH_RD;
      end
      S_DEL_RD: begin
        if (sts.idx_last) begin
          cmd.cnt_dec    = 1'b1;
          cmd.set_status = 1'b1;
          cmd.status     = ST_OK;
          state_next     = S_LIST;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_NEXT;
          state_next = S_DEL_WR;
        end
      end
      S_DEL_WR: begin
        cmd.mem_we = 1'b1;
        cmd.idx_op = IDX_INC;
        state_next = S_DEL_RD;
      end
      S_LIST: begin
        cmd.idx_op = IDX_ZERO;
        if (sts.empty) begin
          cmd.out_load_empty = 1'b1;
          state_next         = S_OUT;
        end else begin
          state_next = S_LS_RD;
        end
      end
      S_LS_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_LS_DIV;
      end
      S_LS_DIV: begin
        cmd.div_start = 1'b1;
        state_next    = S_LS_WAIT;
      end
      S_LS_WAIT: begin
        if (sts.div_done) begin
          cmd.out_load_entry = 1'b1;
          state_next         = S_OUT;
        end
      end
      S_OUT: begin
        if (sts.out_taken) begin
          if (sts.out_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.idx_op = IDX_INC;
            state_next = S_LS_RD;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    sts.div_done |-> (state == S_LS_WAIT))
    else $error("divider done outside wait");

  a_taken_in_out: assert property (@(posedge clk) disable iff (rst)
    sts.out_taken |-> (state == S_OUT))
    else $error("result taken outside output state");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && sts.out_taken && sts.out_last) |=> (state == S_IDLE))
    else $error("last result did not end the item");

  a_accept_check: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && in_valid) |=> (state == S_CHECK))
    else $error("accepted item not checked");

endmodule

>>> hw/rtl/sorted_key_table_core.sv
`timescale 1ns / 1ps
// One item at a time; the input stalls from acceptance until its last result is taken.
// Update: add scans the keys for the insert point (stopping on a duplicate), then shifts
// the entries above it up from the end; rejected when full. Delete shifts the entries
// above the position down; rejected on a bad position. Listing: per entry a read,
// divider start, divide and done, result load; or one empty result; plus output stall.
// Sync active-high reset: table empty, unit_time 1, no result pending; keys not cleared.
module sorted_key_table_core
  import skt_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [KEY_W-1:0] cfg_wdata,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_item,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_item
);

  cmd_t cmd;
  sts_t sts;

  skt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  skt_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
